/* sv/rc4_pkg.sv */
// Shared constants, control word and status types for the RC4 cipher block.
package rc4_pkg;

    localparam int STATE_SIZE = 256;
    localparam int STATE_AW   = $clog2(STATE_SIZE);
    localparam int KEY_BYTES  = 256;
    localparam int BYTE_W     = 8;
    localparam int KLEN_W     = 9;
    localparam int PC_W       = 4;

    localparam logic [KLEN_W-1:0] KEY_LENGTH_RST = 9'd16;

    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_SCHED = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    // permutation read address select
    localparam logic [1:0] RA_N     = 2'd0;
    localparam logic [1:0] RA_IPLUS = 2'd1;
    localparam logic [1:0] RA_JNEW  = 2'd2;
    localparam logic [1:0] RA_SUM   = 2'd3;

    // permutation write address select
    localparam logic [1:0] WA_N = 2'd0;
    localparam logic [1:0] WA_I = 2'd1;
    localparam logic [1:0] WA_J = 2'd2;

    // permutation write data select
    localparam logic [1:0] WD_N     = 2'd0;
    localparam logic [1:0] WD_RDATA = 2'd1;
    localparam logic [1:0] WD_SI    = 2'd2;

    // sequencer jumps
    localparam logic [1:0] J_NEXT     = 2'd0;
    localparam logic [1:0] J_GOTO     = 2'd1;
    localparam logic [1:0] J_DISPATCH = 2'd2;
    localparam logic [1:0] J_LOOP     = 2'd3;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_SCHED    = 4'd1;
    localparam logic [PC_W-1:0] PC_FILL     = 4'd2;
    localparam logic [PC_W-1:0] PC_KSA0     = 4'd3;
    localparam logic [PC_W-1:0] PC_KSA1     = 4'd4;
    localparam logic [PC_W-1:0] PC_KSA2     = 4'd5;
    localparam logic [PC_W-1:0] PC_KSA3     = 4'd6;
    localparam logic [PC_W-1:0] PC_SCH_END  = 4'd7;
    localparam logic [PC_W-1:0] PC_DATA     = 4'd8;
    localparam logic [PC_W-1:0] PC_DATA1    = 4'd9;
    localparam logic [PC_W-1:0] PC_DATA2    = 4'd10;
    localparam logic [PC_W-1:0] PC_DATA3    = 4'd11;

    typedef struct packed {
        logic            accept;
        logic            re;
        logic [1:0]      ra_sel;
        logic            we;
        logic [1:0]      wa_sel;
        logic [1:0]      wd_sel;
        logic            ld_i;
        logic            ld_j;
        logic            add_key;
        logic            ld_si;
        logic            ld_sj;
        logic            clr_n;
        logic            inc_n;
        logic            inc_pos;
        logic            clr_ij;
        logic            emit;
        logic [1:0]      jmp;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic go_sched;
        logic go_data;
        logic n_last;
        logic stall;
    } t_stat;

    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = '0;
        case (pc)
            PC_IDLE: begin
                c.accept = 1'b1;
                c.jmp    = J_DISPATCH;
            end
            PC_SCHED: begin
                c.clr_n = 1'b1;
            end
            PC_FILL: begin
                c.we     = 1'b1;
                c.wa_sel = WA_N;
                c.wd_sel = WD_N;
                c.inc_n  = 1'b1;
                c.jmp    = J_LOOP;
                c.target = PC_FILL;
            end
            PC_KSA0: begin
                c.re     = 1'b1;
                c.ra_sel = RA_N;
            end
            PC_KSA1: begin
                c.re      = 1'b1;
                c.ra_sel  = RA_JNEW;
                c.ld_j    = 1'b1;
                c.add_key = 1'b1;
                c.ld_si   = 1'b1;
            end
            PC_KSA2: begin
                c.we     = 1'b1;
                c.wa_sel = WA_N;
                c.wd_sel = WD_RDATA;
            end
            PC_KSA3: begin
                c.we      = 1'b1;
                c.wa_sel  = WA_J;
                c.wd_sel  = WD_SI;
                c.inc_n   = 1'b1;
                c.inc_pos = 1'b1;
                c.jmp     = J_LOOP;
                c.target  = PC_KSA0;
            end
            PC_SCH_END: begin
                c.clr_ij = 1'b1;
                c.jmp    = J_GOTO;
                c.target = PC_IDLE;
            end
            PC_DATA: begin
                c.re     = 1'b1;
                c.ra_sel = RA_IPLUS;
                c.ld_i   = 1'b1;
            end
            PC_DATA1: begin
                c.re     = 1'b1;
                c.ra_sel = RA_JNEW;
                c.ld_j   = 1'b1;
                c.ld_si  = 1'b1;
            end
            PC_DATA2: begin
                c.re     = 1'b1;
                c.ra_sel = RA_SUM;
                c.ld_sj  = 1'b1;
                c.we     = 1'b1;
                c.wa_sel = WA_I;
                c.wd_sel = WD_RDATA;
            end
            PC_DATA3: begin
                c.we     = 1'b1;
                c.wa_sel = WA_J;
                c.wd_sel = WD_SI;
                c.emit   = 1'b1;
                c.jmp    = J_GOTO;
                c.target = PC_IDLE;
            end
            default: begin
                c.jmp    = J_GOTO;
                c.target = PC_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

/* sv/rc4_stream_cipher_top.sv */
// Top level of the RC4 stream cipher block.
// Input items arrive on i_in_valid / o_in_ready with an action code:
//   key write stores i_key_byte at i_key_index (no result),
//   schedule loads the identity permutation and runs the key schedule
//   over the first key_length key bytes, then clears i and j (no result),
//   data XORs i_data_byte with the next keystream byte; i_last_in
//   clears i and j after that byte.
// Results leave on o_out_valid / i_out_ready through an output register.
// A short microcode program steps a datapath around one permutation RAM
// with one read and one write port, so one item is in work at a time:
//   key write in the idle step, data through PC_DATA to PC_DATA3,
//   schedule through 256 fill steps, then PC_KSA0 to PC_KSA3 for each
//   key schedule step.
// A waiting result does not block new items; a data item only holds in its
// last step while the previous result is still untaken.
// key_length is written through i_cfg_we / i_cfg_wdata, resets to 16.
// Reset clears i, j, the sequencer and the output valid; permutation and
// key contents are undefined until a schedule and key writes load them.
module rc4_stream_cipher_top #(
    parameter int KEY_BYTES = rc4_pkg::KEY_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rc4_pkg::KLEN_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [7:0]                  i_key_index,
    input  logic [7:0]                  i_key_byte,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_data_out
);

    logic [rc4_pkg::KLEN_W-1:0] r_key_length;
    rc4_pkg::t_ctrl             ctrl;
    rc4_pkg::t_stat             stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= rc4_pkg::KEY_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_key_length <= i_cfg_wdata;
        end
    end

    rc4_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    rc4_dp #(
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_key_length (r_key_length),
        .i_in_valid   (i_in_valid),
        .i_action     (i_action),
        .i_key_index  (i_key_index),
        .i_key_byte   (i_key_byte),
        .i_data_byte  (i_data_byte),
        .i_last_in    (i_last_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data_out   (o_data_out)
    );

    assign o_in_ready = ctrl.accept && i_rst_n;

endmodule

/* sv/rc4_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rc4_seq.sv */
// Microcode sequencer: step counter, control ROM and jump logic.
module rc4_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rc4_pkg::t_stat  i_stat,
    output rc4_pkg::t_ctrl  o_ctrl
);

    logic [rc4_pkg::PC_W-1:0] r_pc;
    logic [rc4_pkg::PC_W-1:0] n_pc;
    rc4_pkg::t_ctrl           ctrl;

    assign ctrl   = rc4_pkg::ucode(r_pc);
    assign o_ctrl = ctrl;

    always_comb begin
        n_pc = r_pc + 1'b1;
        case (ctrl.jmp)
            rc4_pkg::J_NEXT:  n_pc = r_pc + 1'b1;
            rc4_pkg::J_GOTO:  n_pc = ctrl.target;
            rc4_pkg::J_DISPATCH: begin
                if (i_stat.go_sched) begin
                    n_pc = rc4_pkg::PC_SCHED;
                end else if (i_stat.go_data) begin
                    n_pc = rc4_pkg::PC_DATA;
                end else begin
                    n_pc = r_pc;
                end
            end
            rc4_pkg::J_LOOP:  n_pc = i_stat.n_last ? r_pc + 1'b1 : ctrl.target;
            default:          n_pc = rc4_pkg::PC_IDLE;
        endcase
        if (i_stat.stall) begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rc4_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* sv/rc4_dp.sv */
// Datapath: permutation and key RAMs, index registers, swap and output register.
module rc4_dp #(
    parameter int KEY_BYTES = rc4_pkg::KEY_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rc4_pkg::t_ctrl              i_ctrl,
    output rc4_pkg::t_stat              o_stat,
    input  logic [rc4_pkg::KLEN_W-1:0]  i_key_length,
    input  logic                        i_in_valid,
    input  logic [1:0]                  i_action,
    input  logic [7:0]                  i_key_index,
    input  logic [7:0]                  i_key_byte,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_data_out
);

    localparam int KAW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int SAW = rc4_pkg::STATE_AW;
    localparam int BW  = rc4_pkg::BYTE_W;
    localparam int LW  = rc4_pkg::KLEN_W;

    logic [SAW-1:0] r_i, r_j, r_n;
    logic [BW-1:0]  r_si, r_sj;
    logic [KAW-1:0] r_pos;
    logic [BW-1:0]  r_dat;
    logic           r_last;
    logic           r_out_valid;
    logic [BW-1:0]  r_data_out;

    logic [BW-1:0]  s_rdata;
    logic [BW-1:0]  k_rdata;
    logic [SAW-1:0] s_raddr, s_waddr;
    logic [BW-1:0]  s_wdata;
    logic [SAW-1:0] j_new;
    logic [SAW-1:0] sum_a, sum_d;
    logic [LW-1:0]  len_eff;
    logic [LW-1:0]  pos_inc;
    logic [KAW-1:0] pos_next;
    logic           accepted;
    logic           key_we;
    logic           stall;
    logic           fire;
    logic [BW-1:0]  ks;

    assign accepted = i_ctrl.accept && i_in_valid && i_rst_n;
    assign key_we   = accepted && (i_action == rc4_pkg::ACT_KEY)
                      && ({1'b0, i_key_index} < LW'(KEY_BYTES));
    assign stall    = i_ctrl.emit && r_out_valid && !i_out_ready;
    assign fire     = i_ctrl.emit && !stall;

    assign o_stat.go_sched = accepted && (i_action == rc4_pkg::ACT_SCHED);
    assign o_stat.go_data  = accepted && (i_action == rc4_pkg::ACT_DATA);
    assign o_stat.n_last   = (r_n == '1);
    assign o_stat.stall    = stall;

    assign j_new = r_j + s_rdata + (i_ctrl.add_key ? k_rdata : '0);
    assign sum_a = r_si + s_rdata;
    assign sum_d = r_si + r_sj;

    always_comb begin
        if (i_key_length == '0) begin
            len_eff = LW'(1);
        end else if (i_key_length > LW'(KEY_BYTES)) begin
            len_eff = LW'(KEY_BYTES);
        end else begin
            len_eff = i_key_length;
        end
    end

    assign pos_inc  = LW'(r_pos) + LW'(1);
    assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[KAW-1:0];

    always_comb begin
        case (i_ctrl.ra_sel)
            rc4_pkg::RA_N:     s_raddr = r_n;
            rc4_pkg::RA_IPLUS: s_raddr = r_i + 1'b1;
            rc4_pkg::RA_JNEW:  s_raddr = j_new;
            rc4_pkg::RA_SUM:   s_raddr = sum_a;
            default:           s_raddr = r_n;
        endcase
        case (i_ctrl.wa_sel)
            rc4_pkg::WA_N: s_waddr = r_n;
            rc4_pkg::WA_I: s_waddr = r_i;
            rc4_pkg::WA_J: s_waddr = r_j;
            default:       s_waddr = r_n;
        endcase
        case (i_ctrl.wd_sel)
            rc4_pkg::WD_N:     s_wdata = r_n;
            rc4_pkg::WD_RDATA: s_wdata = s_rdata;
            rc4_pkg::WD_SI:    s_wdata = r_si;
            default:           s_wdata = s_rdata;
        endcase
    end

    // sum read happens before the swap lands; patch the two swapped entries
    always_comb begin
        if (sum_d == r_j) begin
            ks = r_si;
        end else if (sum_d == r_i) begin
            ks = r_sj;
        end else begin
            ks = s_rdata;
        end
    end

    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (rc4_pkg::STATE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (i_ctrl.re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (KEY_BYTES)
    ) u_key (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (i_key_index[KAW-1:0]),
        .i_wdata (i_key_byte),
        .i_re    (i_ctrl.re),
        .i_raddr (r_pos),
        .o_rdata (k_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.clr_ij || (fire && r_last)) begin
                r_i <= '0;
            end else if (i_ctrl.ld_i) begin
                r_i <= r_i + 1'b1;
            end
            if (i_ctrl.clr_ij || i_ctrl.clr_n || (fire && r_last)) begin
                r_j <= '0;
            end else if (i_ctrl.ld_j) begin
                r_j <= j_new;
            end
            if (i_ctrl.clr_n) begin
                r_n   <= '0;
                r_pos <= '0;
            end else begin
                if (i_ctrl.inc_n) begin
                    r_n <= r_n + 1'b1;
                end
                if (i_ctrl.inc_pos) begin
                    r_pos <= pos_next;
                end
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_dat  <= i_data_byte;
            r_last <= i_last_in;
        end
        if (i_ctrl.ld_si) begin
            r_si <= s_rdata;
        end
        if (i_ctrl.ld_sj) begin
            r_sj <= s_rdata;
        end
        if (fire) begin
            r_data_out <= r_dat ^ ks;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;

endmodule
